@@ rtl/tpfg_pkg.sv @@
// Shared widths, constants and register codes of the thermal frequency governor.
package tpfg_pkg;

    localparam int ERROR_SLOTS    = 8;
    localparam int CEILING_MARGIN = 0;
    localparam int PI_PERIOD      = 1;

    localparam int TEMP_W     = 19;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int GAIN_W     = 16;
    localparam int FREQ_W     = 22;
    localparam int OUT_W      = 23;
    localparam int MODE_W     = 2;
    localparam int ACC_W      = 48;
    localparam int ERR_W      = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 22;

    localparam int SLOT_W  = (ERROR_SLOTS > 1) ? $clog2(ERROR_SLOTS) : 1;
    localparam int PHASE_W = (PI_PERIOD > 1) ? $clog2(PI_PERIOD) : 1;
    localparam int SUM_W   = ERR_W + $clog2(ERROR_SLOTS);
    localparam int MUL_W   = SUM_W + GAIN_W + 1;
    localparam int PI_W    = MUL_W + 1;

    localparam int DIVISOR  = 100;
    localparam int REM_W    = 7;
    localparam int DIV_STEP = 16;
    localparam int DIV_W    = ((PI_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_CNT  = DIV_W / DIV_STEP;
    localparam int DCNT_W   = (DIV_CNT > 1) ? $clog2(DIV_CNT) : 1;
    localparam int WIDE_W   = ((ACC_W > DIV_W + 1) ? ACC_W : DIV_W + 1) + 1;

    localparam int DIG_W       = REM_W + DIV_STEP;
    localparam int RECIP_SHIFT = DIG_W + REM_W;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = DIG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_RESET = ACC_W'(4000000 + CEILING_MARGIN);

    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PI        = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_GAIN     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_TEMP = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FREQ = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ      = 4'd7;

endpackage

@@ rtl/thermal_pi_frequency_governor_unit.sv @@
// Top level of the thermal governor: threshold law and a sequenced PI step.
// Threshold, held and off-period ticks go through DECIDE and OUT before their result is presented.
// A PI step runs ERR, RING, PMUL, IMUL, PISUM, the divider, ACC, CLAMP, REQ and OUT; a negative error is first scaled.
// The divide by 100 is a reciprocal multiply on 16-bit digits, one digit per cycle.
// One item is in flight at a time, so a new item is taken only once the last result is loaded into the output.
// Reset is asynchronous and restores the register defaults, the empty ring and the accumulator.
module thermal_pi_frequency_governor_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tpfg_pkg::TEMP_W-1:0]    temperature,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [tpfg_pkg::OUT_W-1:0]     freq_target,
    output logic                                  freq_changed,
    output logic                                  throttle_flag,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [tpfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [tpfg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tpfg_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_ERR     = 4'd2;
    localparam logic [3:0] S_COOLMUL = 4'd3;
    localparam logic [3:0] S_DLOAD   = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_DFIX    = 4'd6;
    localparam logic [3:0] S_RING    = 4'd7;
    localparam logic [3:0] S_PMUL    = 4'd8;
    localparam logic [3:0] S_IMUL    = 4'd9;
    localparam logic [3:0] S_PISUM   = 4'd10;
    localparam logic [3:0] S_ACC     = 4'd11;
    localparam logic [3:0] S_CLAMP   = 4'd12;
    localparam logic [3:0] S_REQ     = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    localparam logic DSEL_COOL = 1'b0;
    localparam logic DSEL_PI   = 1'b1;

    logic [MODE_W-1:0]        mode_reg;
    logic signed [TEMP_W-1:0] target_temp_reg;
    logic [GAIN_W-1:0]        p_gain_reg;
    logic [GAIN_W-1:0]        i_gain_reg;
    logic [GAIN_W-1:0]        cool_gain_reg;
    logic signed [TEMP_W-1:0] throttle_temp_reg;
    logic [FREQ_W-1:0]        throttle_freq_reg;
    logic [FREQ_W-1:0]        max_freq_reg;

    logic [3:0]               state_reg;
    logic                     div_sel_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic [31:0]              tick_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        ring_addr_reg;
    logic [ERROR_SLOTS-1:0]   ring_valid_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  accum_reg;
    logic [OUT_W-1:0]         last_request_reg;
    logic                     changed_reg;
    logic                     hot_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         freq_target_reg;
    logic                     freq_changed_reg;
    logic                     throttle_flag_reg;

    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [PI_W-1:0]   prod_reg;
    logic signed [MUL_W-1:0]  mulr_reg;
    logic [DIV_W-1:0]         div_q_reg;
    logic [REM_W-1:0]         div_r_reg;
    logic                     div_neg_reg;
    logic signed [DIV_W:0]    div_res_reg;
    logic signed [WIDE_W-1:0] acc_sum_reg;

    logic signed [ERR_W-1:0]  ring_mem [ERROR_SLOTS];
    logic signed [ERR_W-1:0]  ring_rd_reg;
    logic                     ring_we;

    logic                     hot;
    logic [OUT_W-1:0]         thr_freq;
    logic                     advance;
    logic [31:0]              tick_next;
    logic [PHASE_W-1:0]       phase_next;
    logic [SLOT_W-1:0]        slot_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  mul_a;
    logic [GAIN_W-1:0]        mul_b;
    logic signed [GAIN_W:0]   mul_bs;
    logic signed [MUL_W-1:0]  mul_p;
    logic [PI_W-1:0]          mag;
    logic [DIG_W-1:0]         div_x;
    logic [PROD_W-1:0]        div_prod;
    logic [DIV_STEP-1:0]      div_digit;
    logic [DIG_W-1:0]         div_back;
    logic [DIG_W-1:0]         div_rem;
    logic [DIV_W-1:0]         div_q_next;
    logic [REM_W-1:0]         div_r_next;
    logic signed [DIV_W:0]    dq_s;
    logic signed [DIV_W:0]    div_val;
    logic signed [ERR_W-1:0]  ring_old;
    logic signed [WIDE_W-1:0] ceil_w;
    logic signed [WIDE_W-1:0] acc_min_w;
    logic [OUT_W-1:0]         req_val;
    logic                     out_load;

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign freq_target   = freq_target_reg;
    assign freq_changed  = freq_changed_reg;
    assign throttle_flag = throttle_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_THRESHOLD;
            target_temp_reg   <= TEMP_W'(85000);
            p_gain_reg        <= '0;
            i_gain_reg        <= '0;
            cool_gain_reg     <= GAIN_W'(100);
            throttle_temp_reg <= TEMP_W'(90000);
            throttle_freq_reg <= '0;
            max_freq_reg      <= FREQ_W'(4000000);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CONTROL_MODE:  mode_reg          <= cfg_data[MODE_W-1:0];
                REG_TARGET_TEMP:   target_temp_reg   <= cfg_data[TEMP_W-1:0];
                REG_P_GAIN:        p_gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_I_GAIN:        i_gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_COOL_GAIN:     cool_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_THROTTLE_TEMP: throttle_temp_reg <= cfg_data[TEMP_W-1:0];
                REG_THROTTLE_FREQ: throttle_freq_reg <= cfg_data[FREQ_W-1:0];
                REG_MAX_FREQ:      max_freq_reg      <= cfg_data[FREQ_W-1:0];
                default:           ;
            endcase
        end
    end

    assign hot      = (temp_reg >= throttle_temp_reg);
    assign thr_freq = hot ? OUT_W'(throttle_freq_reg) : OUT_W'(max_freq_reg);
    assign advance  = (mode_reg == MODE_THRESHOLD) || (mode_reg == MODE_PI)
                      || (phase_reg != '0);
    assign diff     = DIFF_W'(target_temp_reg) - DIFF_W'(temp_reg);

    always_comb
    begin
        tick_next  = tick_reg + 32'd1;
        phase_next = phase_reg + PHASE_W'(1);
        slot_next  = slot_reg;
        if (tick_reg == '1)
        begin
            phase_next = '0;
            slot_next  = '0;
        end
        else if (phase_reg == PHASE_W'(PI_PERIOD - 1))
        begin
            phase_next = '0;
            slot_next  = (slot_reg == SLOT_W'(ERROR_SLOTS - 1)) ? '0 : slot_reg + SLOT_W'(1);
        end
    end

    always_comb
    begin
        mul_a = sum_reg;
        mul_b = i_gain_reg;
        case (state_reg)
            S_COOLMUL:
            begin
                mul_a = SUM_W'(err_reg);
                mul_b = cool_gain_reg;
            end
            S_PMUL:
            begin
                mul_a = SUM_W'(err_reg);
                mul_b = p_gain_reg;
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = i_gain_reg;
            end
        endcase
    end

    assign mul_bs = $signed({1'b0, mul_b});
    assign mul_p  = MUL_W'(mul_a) * MUL_W'(mul_bs);
    assign mag    = prod_reg[PI_W-1] ? PI_W'(-prod_reg) : PI_W'(prod_reg);

    always_comb
    begin
        div_x      = {div_r_reg, div_q_reg[DIV_W-1 -: DIV_STEP]};
        div_prod   = PROD_W'(div_x) * PROD_W'(RECIP);
        div_digit  = div_prod[RECIP_SHIFT +: DIV_STEP];
        div_back   = DIG_W'(div_digit) * DIG_W'(DIVISOR);
        div_rem    = div_x - div_back;
        div_q_next = {div_q_reg[DIV_W-DIV_STEP-1:0], div_digit};
        div_r_next = div_rem[REM_W-1:0];
    end

    assign dq_s      = $signed({1'b0, div_q_reg});
    assign div_val   = div_neg_reg ? -dq_s : dq_s;
    assign ring_old  = ring_valid_reg[ring_addr_reg] ? ring_rd_reg : '0;
    assign ceil_w    = WIDE_W'(max_freq_reg) + WIDE_W'(CEILING_MARGIN);
    assign acc_min_w = WIDE_W'(ACC_MIN);

    always_comb
    begin
        if (accum_reg[ACC_W-1])
        begin
            req_val = '0;
        end
        else if (|accum_reg[ACC_W-2:OUT_W])
        begin
            req_val = '1;
        end
        else
        begin
            req_val = accum_reg[OUT_W-1:0];
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign ring_we  = (state_reg == S_RING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            div_sel_reg       <= DSEL_COOL;
            div_cnt_reg       <= '0;
            tick_reg          <= '0;
            phase_reg         <= '0;
            slot_reg          <= '0;
            ring_addr_reg     <= '0;
            ring_valid_reg    <= '0;
            sum_reg           <= '0;
            accum_reg         <= ACC_RESET;
            last_request_reg  <= '0;
            changed_reg       <= 1'b0;
            hot_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            freq_target_reg   <= '0;
            freq_changed_reg  <= 1'b0;
            throttle_flag_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    hot_reg       <= hot;
                    changed_reg   <= (mode_reg == MODE_THRESHOLD)
                                     && (thr_freq != last_request_reg);
                    ring_addr_reg <= slot_reg;
                    if (advance)
                    begin
                        tick_reg  <= tick_next;
                        phase_reg <= phase_next;
                        slot_reg  <= slot_next;
                    end
                    if (mode_reg == MODE_THRESHOLD)
                    begin
                        last_request_reg <= thr_freq;
                        state_reg        <= S_OUT;
                    end
                    else if ((phase_reg == '0) && (mode_reg == MODE_PI))
                    begin
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_ERR:
                begin
                    state_reg <= err_reg[ERR_W-1] ? S_COOLMUL : S_RING;
                end
                S_COOLMUL:
                begin
                    div_sel_reg <= DSEL_COOL;
                    state_reg   <= S_DLOAD;
                end
                S_DLOAD:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(DIV_CNT - 1))
                    begin
                        state_reg <= S_DFIX;
                    end
                end
                S_DFIX:
                begin
                    state_reg <= (div_sel_reg == DSEL_COOL) ? S_RING : S_ACC;
                end
                S_RING:
                begin
                    sum_reg                       <= sum_reg - SUM_W'(ring_old) + SUM_W'(err_reg);
                    ring_valid_reg[ring_addr_reg] <= 1'b1;
                    state_reg                     <= S_PMUL;
                end
                S_PMUL:
                begin
                    state_reg <= S_IMUL;
                end
                S_IMUL:
                begin
                    state_reg <= S_PISUM;
                end
                S_PISUM:
                begin
                    div_sel_reg <= DSEL_PI;
                    state_reg   <= S_DLOAD;
                end
                S_ACC:
                begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (acc_sum_reg > ceil_w)
                    begin
                        accum_reg <= ACC_W'(ceil_w);
                    end
                    else if (acc_sum_reg < acc_min_w)
                    begin
                        accum_reg <= ACC_MIN;
                    end
                    else
                    begin
                        accum_reg <= ACC_W'(acc_sum_reg);
                    end
                    state_reg <= S_REQ;
                end
                S_REQ:
                begin
                    if (req_val != last_request_reg)
                    begin
                        last_request_reg <= req_val;
                        changed_reg      <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        freq_target_reg   <= last_request_reg;
                        freq_changed_reg  <= changed_reg;
                        throttle_flag_reg <= hot_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    temp_reg <= temperature;
                end
            end
            S_DECIDE:
            begin
                err_reg <= ERR_W'(diff);
            end
            S_COOLMUL:
            begin
                prod_reg <= PI_W'(mul_p);
            end
            S_DLOAD:
            begin
                div_q_reg   <= DIV_W'(mag);
                div_r_reg   <= '0;
                div_neg_reg <= prod_reg[PI_W-1];
            end
            S_DIV:
            begin
                div_q_reg <= div_q_next;
                div_r_reg <= div_r_next;
            end
            S_DFIX:
            begin
                if (div_sel_reg == DSEL_COOL)
                begin
                    err_reg <= ERR_W'(div_val);
                end
                else
                begin
                    div_res_reg <= div_val;
                end
            end
            S_PMUL:
            begin
                prod_reg <= PI_W'(mul_p);
            end
            S_IMUL:
            begin
                mulr_reg <= mul_p;
            end
            S_PISUM:
            begin
                prod_reg <= prod_reg + PI_W'(mulr_reg);
            end
            S_ACC:
            begin
                acc_sum_reg <= WIDE_W'(accum_reg) + WIDE_W'(div_res_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_addr_reg] <= err_reg;
        end
        ring_rd_reg <= ring_mem[ring_addr_reg];
    end

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_r_reg < REM_W'(DIVISOR)))
        else $error("divider remainder out of range");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (div_cnt_reg == DCNT_W'(DIV_CNT - 1)) |=>
        (state_reg == S_DFIX))
        else $error("divider did not finish on its last step");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg <= PHASE_W'(PI_PERIOD - 1)) && (slot_reg <= SLOT_W'(ERROR_SLOTS - 1)))
        else $error("tick phase or ring slot out of range");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg == S_DECIDE))
        else $error("accepted item did not start processing");

    a_pi_only_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) && (mode_reg != MODE_PI) |=> (state_reg == S_OUT))
        else $error("PI step started outside PI mode");
`endif

endmodule

@@ tb/tb_thermal_pi_frequency_governor_unit.sv @@
// Self-checking testbench for the thermal governor: threshold, PI and held modes under random flow control.
module tb_thermal_pi_frequency_governor_unit;
    import tpfg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD_ALT = 2'd3;
    localparam int TEMP_LO     = -40000;
    localparam int TEMP_HI     = 150000;
    localparam int FREQ_HI     = 4000000;
    localparam int GAIN_HI     = 65535;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [OUT_W-1:0] freq;
        logic             changed;
        logic             hot;
    } request_t;

    class governor_scoreboard;
        logic [MODE_W-1:0] mode;
        longint tgt, kp, ki, kcool, hot_temp, hot_freq, top_freq;
        int err_ring[ERROR_SLOTS];
        int unsigned ticks_seen;
        longint accum;
        logic [OUT_W-1:0] last_req;
        request_t expected_requests[$];
        int errors, n_ticks, n_pi, n_held, n_hot, n_changed, n_floor;

        function new();
            mode = MODE_THRESHOLD;
            tgt = 85000;
            kp = 0;
            ki = 0;
            kcool = 100;
            hot_temp = 90000;
            hot_freq = 0;
            top_freq = 4000000;
            foreach (err_ring[k]) err_ring[k] = 0;
            ticks_seen = 0;
            accum = longint'(ACC_RESET);
            last_req = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_CONTROL_MODE:  mode = d[MODE_W-1:0];
                REG_TARGET_TEMP:   tgt = longint'($signed(d[TEMP_W-1:0]));
                REG_P_GAIN:        kp = d[GAIN_W-1:0];
                REG_I_GAIN:        ki = d[GAIN_W-1:0];
                REG_COOL_GAIN:     kcool = d[GAIN_W-1:0];
                REG_THROTTLE_TEMP: hot_temp = longint'($signed(d[TEMP_W-1:0]));
                REG_THROTTLE_FREQ: hot_freq = d[FREQ_W-1:0];
                REG_MAX_FREQ:      top_freq = d[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic signed [TEMP_W-1:0] t);
            longint tv, err, sum, req;
            bit hot, changed, advance;
            int unsigned slot;
            request_t r;
            tv = t;
            hot = tv >= hot_temp;
            changed = 0;
            advance = 1;
            if (mode == MODE_THRESHOLD) begin
                req = hot ? hot_freq : top_freq;
                if (OUT_W'(req) != last_req) begin
                    last_req = OUT_W'(req);
                    changed = 1;
                end
            end else if (ticks_seen % PI_PERIOD == 0) begin
                if (mode != MODE_PI) begin
                    advance = 0;
                    n_held++;
                end else begin
                    n_pi++;
                    err = tgt - tv;
                    if (err < 0)
                        err = (err * kcool) / DIVISOR;
                    slot = (ticks_seen / PI_PERIOD) % ERROR_SLOTS;
                    err_ring[slot] = int'(err);
                    sum = 0;
                    foreach (err_ring[k]) sum += err_ring[k];
                    accum += (kp * err + ki * sum) / DIVISOR;
                    if (accum > top_freq + CEILING_MARGIN)
                        accum = top_freq + CEILING_MARGIN;
                    if (accum < longint'(ACC_MIN)) begin
                        accum = longint'(ACC_MIN);
                        n_floor++;
                    end
                    req = accum;
                    if (req < 0)
                        req = 0;
                    if (req > longint'({OUT_W{1'b1}}))
                        req = longint'({OUT_W{1'b1}});
                    if (OUT_W'(req) != last_req) begin
                        last_req = OUT_W'(req);
                        changed = 1;
                    end
                end
            end
            if (advance)
                ticks_seen++;
            n_ticks++;
            n_hot += hot;
            n_changed += changed;
            r.freq = last_req;
            r.changed = changed;
            r.hot = hot;
            expected_requests.push_back(r);
        endfunction

        function void check_request(logic [OUT_W-1:0] f, logic c, logic h);
            request_t e;
            if (expected_requests.size() == 0) begin
                $error("result with no item pending: freq_target %0d", f);
                errors++;
                return;
            end
            e = expected_requests.pop_front();
            if (f !== e.freq) begin
                $error("freq_target: expected %0d, got %0d", e.freq, f);
                errors++;
            end
            if (c !== e.changed) begin
                $error("freq_changed: expected %0d, got %0d", e.changed, c);
                errors++;
            end
            if (h !== e.hot) begin
                $error("throttle_flag: expected %0d, got %0d", e.hot, h);
                errors++;
            end
        endfunction

        function int pending();
            return expected_requests.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [OUT_W-1:0] freq_target;
    logic freq_changed;
    logic throttle_flag;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    governor_scoreboard sb;
    int send_idle = 0;
    int stall_pct = 0;
    int temp_center = 85000;
    int quiet_cycles = 0;

    thermal_pi_frequency_governor_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .temperature(temperature),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .freq_target(freq_target),
        .freq_changed(freq_changed),
        .throttle_flag(throttle_flag),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_tick(temperature);
            if (out_valid && !out_stall)
                sb.check_request(freq_target, freq_changed, throttle_flag);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
            $display("tb_thermal_pi_frequency_governor_unit: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int pick(int lo, int hi);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int random_temp();
        int r;
        int t;
        r = $urandom_range(7);
        if (r == 0)
            return $urandom_range(1) ? TEMP_HI : TEMP_LO;
        if (r < 3)
            return pick(TEMP_LO, TEMP_HI);
        t = temp_center + int'($urandom_range(6000)) - 3000;
        if (t < TEMP_LO)
            t = TEMP_LO;
        if (t > TEMP_HI)
            t = TEMP_HI;
        return t;
    endfunction

    task automatic send_tick(input int t);
        if (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        temperature <= TEMP_W'(t);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val, input int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(val) & keep);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [MODE_W-1:0] m, input int tgt, input int kp,
                             input int ki, input int kc, input int ht, input int hf,
                             input int mf);
        settle();
        if ($urandom_range(1))
            write_reg(REG_MAX_FREQ + CFG_IDX_W'($urandom_range(8, 1)), $urandom, CFG_DATA_W);
        write_reg(REG_CONTROL_MODE, int'(m), MODE_W);
        write_reg(REG_TARGET_TEMP, tgt, TEMP_W);
        write_reg(REG_P_GAIN, kp, GAIN_W);
        write_reg(REG_I_GAIN, ki, GAIN_W);
        write_reg(REG_COOL_GAIN, kc, GAIN_W);
        write_reg(REG_THROTTLE_TEMP, ht, TEMP_W);
        write_reg(REG_THROTTLE_FREQ, hf, FREQ_W);
        write_reg(REG_MAX_FREQ, mf, FREQ_W);
        cfg_valid <= 1'b0;
        temp_center = (m == MODE_THRESHOLD) ? ht : tgt;
    endtask

    task automatic random_config();
        logic [MODE_W-1:0] modes[6];
        int tgt, ht;
        modes = '{MODE_THRESHOLD, MODE_PI, MODE_PI, MODE_PI, MODE_HOLD, MODE_HOLD_ALT};
        tgt = pick(TEMP_LO, TEMP_HI);
        ht = pick(TEMP_LO, TEMP_HI);
        configure(modes[$urandom_range(5)], tgt,
                  $urandom_range(3) == 0 ? pick(0, GAIN_HI) : int'($urandom_range(400)),
                  $urandom_range(3) == 0 ? pick(0, GAIN_HI) : int'($urandom_range(100)),
                  $urandom_range(3) == 0 ? pick(0, GAIN_HI) : int'($urandom_range(300)),
                  ht, pick(0, FREQ_HI), pick(0, FREQ_HI));
    endtask

    initial
    begin
        int reset_temps[6];
        int idle_table[4][2];
        sb = new();
        reset_temps = '{TEMP_LO, TEMP_HI, 89999, 90000, 90001, 0};
        idle_table = '{'{0, 0}, '{67, 0}, '{0, 67}, '{8, 8}};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: reset settings first, then each mode and the gain extremes.
        foreach (reset_temps[k]) send_tick(reset_temps[k]);
        configure(MODE_PI, 85000, 200, 50, 150, 40000, 1000000, 3000000);
        send_tick(85000);
        send_tick(60000);
        send_tick(120000);
        send_tick(TEMP_LO);
        send_tick(TEMP_HI);
        send_tick(85000);
        send_tick(70000);
        configure(MODE_HOLD, 85000, 200, 50, 150, 40000, 1000000, 3000000);
        send_tick(20000);
        send_tick(140000);
        send_tick(TEMP_HI);
        configure(MODE_HOLD_ALT, 85000, 200, 50, 150, 40000, 1000000, 3000000);
        send_tick(TEMP_LO);
        send_tick(100000);
        configure(MODE_PI, TEMP_LO, GAIN_HI, GAIN_HI, 0, TEMP_LO, FREQ_HI, FREQ_HI);
        send_tick(TEMP_HI);
        send_tick(TEMP_LO);
        send_tick(TEMP_HI);
        configure(MODE_THRESHOLD, TEMP_HI, 0, 0, GAIN_HI, TEMP_HI, FREQ_HI, 0);
        send_tick(TEMP_HI);
        send_tick(149999);
        send_tick(TEMP_LO);

        for (int seg = 0; seg < 8; seg++)
        begin
            settle();
            send_idle = idle_table[seg / 2][0];
            stall_pct = idle_table[seg / 2][1];
            random_config();
            repeat (50) send_tick(random_temp());
        end

        // Drive the accumulator down to its floor with hot ticks at full gain.
        settle();
        send_idle = 0;
        stall_pct = 0;
        configure(MODE_PI, TEMP_LO, GAIN_HI, GAIN_HI, GAIN_HI, 90000, 2000000, FREQ_HI);
        repeat (230) send_tick(130000 + int'($urandom_range(20000)));
        configure(MODE_THRESHOLD, 85000, 0, 0, 100, 60000, 1500000, 3500000);
        repeat (4) send_tick(random_temp());

        settle();
        repeat (50) @(posedge clk);
        $display("Ran %0d ticks: %0d PI steps, %0d held, %0d hot, %0d request changes.",
                 sb.n_ticks, sb.n_pi, sb.n_held, sb.n_hot, sb.n_changed);
        $display("Accumulator floor reached on %0d steps; %0d mismatches.",
                 sb.n_floor, sb.errors);
        if (sb.errors == 0)
            $display("tb_thermal_pi_frequency_governor_unit: clean");
        else
            $display("tb_thermal_pi_frequency_governor_unit: errors");
        $finish;
    end
endmodule
